@@ sv/pht_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package pht_pkg;

	localparam int TIME_W = 32;
	localparam logic [TIME_W-1:0] TIMEOUT_RESET = 32'd1000;

	typedef enum logic [2:0] {
		OP_ANNOUNCE = 3'd0,
		OP_LEAVE    = 3'd1,
		OP_CONNECT  = 3'd2,
		OP_MARK_SYN = 3'd3,
		OP_TOUCH    = 3'd4,
		OP_SCAN     = 3'd5,
		OP_QUERY    = 3'd6,
		OP_NONE     = 3'd7
	} op_t;

	typedef enum logic [1:0] {
		HS_IDLE         = 2'd0,
		HS_SYN_SENT     = 2'd1,
		HS_SYN_RECEIVED = 2'd2,
		HS_CONFIRMED    = 2'd3
	} hs_t;

	// command broadcast to every cell
	typedef struct packed {
		logic exec;
		logic shift;
		op_t  op;
		logic syn;
		logic ack;
	} cell_cmd_t;

	// per-cell status, or-reduced at the top
	typedef struct packed {
		logic hit;
		logic free;
		logic rs;
		logic ra;
		logic jn;
		logic lf;
		logic present;
		logic conn;
		logic pend_tok;
	} cell_stat_t;

endpackage
`default_nettype wire

@@ sv/peer_handshake_table_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// request flow: a request is registered on acceptance, looked up and applied in ST_EXEC, result
// registered for output; a new request is taken only in ST_IDLE or when the result is taken
// timeout scan: one token pass over the cell chain, held back by output stalls
// the lookup is a parallel compare in every cell; the scan is set by the token chain length
// reset: asynchronous active low, table empty, timeout_q = 1000, no result pending
module peer_handshake_table_core #(
	parameter int PEER_SLOTS = 16,
	parameter int ADDR_BITS  = 48
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_we,
	input  wire logic [pht_pkg::TIME_W-1:0]   cfg_wdata,
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire logic [2:0]                   operation,
	input  wire logic [ADDR_BITS-1:0]         peer_addr,
	input  wire logic [pht_pkg::TIME_W-1:0]   now_time,
	input  wire logic                         flag_syn,
	input  wire logic                         flag_ack,
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output logic                              reply_syn,
	output logic                              reply_ack,
	output logic                              joined,
	output logic                              left,
	output logic [ADDR_BITS-1:0]              event_addr,
	output logic                              present,
	output logic                              connected,
	output logic                              table_full,
	output logic                              last_result
);
	import pht_pkg::*;

	typedef enum logic [2:0] {ST_IDLE, ST_EXEC, ST_SCAN, ST_CLOSE, ST_RESP} state_t;

	state_t               state_q;
	logic [TIME_W-1:0]    timeout_q;
	op_t                  op_q;
	logic [ADDR_BITS-1:0] addr_q;
	logic [TIME_W-1:0]    now_q;
	logic                 syn_q, ack_q;

	cell_cmd_t            cmd;
	cell_stat_t           stat [PEER_SLOTS];
	logic [ADDR_BITS-1:0] laddr [PEER_SLOTS];
	logic [PEER_SLOTS:0]  free_c, tok_c;
	logic [PEER_SLOTS-1:0] hit_vec;

	logic                 hit_any, any_rs, any_ra, any_jn, any_lf, any_pr, any_cn, any_pend;
	logic [ADDR_BITS-1:0] or_addr;
	logic                 can_load, accept;

	assign accept   = in_valid && in_ready;
	assign in_ready = (state_q == ST_IDLE) || (state_q == ST_RESP && out_ready);
	assign can_load = !out_valid || out_ready;

	always_comb begin
		cmd.exec  = (state_q == ST_EXEC);
		cmd.shift = (state_q == ST_EXEC && op_q == OP_SCAN) ||
			(state_q == ST_SCAN && can_load);
		cmd.op    = op_q;
		cmd.syn   = syn_q;
		cmd.ack   = ack_q;
	end

	assign free_c[0] = 1'b0;
	assign tok_c[0]  = (state_q == ST_EXEC);

	for (genvar i = 0; i < PEER_SLOTS; i++) begin : g_cell
		pht_cell #(.ADDR_BITS(ADDR_BITS)) u_cell (
			.clk(clk), .arst_n(arst_n), .cmd(cmd), .addr(addr_q),
			.now_time(now_q), .timeout(timeout_q), .hit_any(hit_any),
			.free_in(free_c[i]), .tok_in(tok_c[i]),
			.free_out(free_c[i+1]), .tok_out(tok_c[i+1]),
			.stat(stat[i]), .leave_addr(laddr[i])
		);
		assign hit_vec[i] = stat[i].hit;
	end

	assign hit_any = |hit_vec;

	always_comb begin
		any_rs = 1'b0; any_ra = 1'b0; any_jn = 1'b0; any_lf = 1'b0;
		any_pr = 1'b0; any_cn = 1'b0; any_pend = 1'b0; or_addr = '0;
		for (int i = 0; i < PEER_SLOTS; i++) begin
			any_rs   = any_rs   | stat[i].rs;
			any_ra   = any_ra   | stat[i].ra;
			any_jn   = any_jn   | stat[i].jn;
			any_lf   = any_lf   | stat[i].lf;
			any_pr   = any_pr   | stat[i].present;
			any_cn   = any_cn   | stat[i].conn;
			any_pend = any_pend | stat[i].pend_tok;
			or_addr  = or_addr  | laddr[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= TIMEOUT_RESET;
		end else if (cfg_we) begin
			timeout_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q   <= op_t'(operation);
			addr_q <= peer_addr;
			now_q  <= now_time;
			syn_q  <= flag_syn;
			ack_q  <= flag_ack;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid   <= 1'b0;
			reply_syn   <= 1'b0;
			reply_ack   <= 1'b0;
			joined      <= 1'b0;
			left        <= 1'b0;
			event_addr  <= '0;
			present     <= 1'b0;
			connected   <= 1'b0;
			table_full  <= 1'b0;
			last_result <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) state_q <= ST_EXEC;
				end
				ST_EXEC: begin
					if (op_q == OP_SCAN) begin
						state_q <= ST_SCAN;
					end else begin
						state_q     <= ST_RESP;
						out_valid   <= 1'b1;
						event_addr  <= addr_q;
						last_result <= 1'b1;
						if (op_q == OP_NONE) begin
							reply_syn <= 1'b0; reply_ack <= 1'b0; joined <= 1'b0;
							left <= 1'b0; present <= 1'b0; connected <= 1'b0;
							table_full <= 1'b0;
						end else begin
							reply_syn  <= any_rs;
							reply_ack  <= any_ra;
							joined     <= any_jn;
							left       <= any_lf;
							present    <= any_pr;
							connected  <= any_cn;
							table_full <= (op_q == OP_ANNOUNCE || op_q == OP_CONNECT) &&
								!hit_any && !free_c[PEER_SLOTS];
						end
					end
				end
				ST_SCAN: begin
					if (can_load) begin
						// token sits on one cell; a pending leave from it goes out
						out_valid   <= any_pend;
						reply_syn   <= 1'b0;
						reply_ack   <= 1'b0;
						joined      <= 1'b0;
						left        <= 1'b1;
						event_addr  <= or_addr;
						present     <= 1'b0;
						connected   <= 1'b0;
						table_full  <= 1'b0;
						last_result <= 1'b0;
						if (tok_c[PEER_SLOTS]) state_q <= ST_CLOSE;
					end
				end
				ST_CLOSE: begin
					if (can_load) begin
						out_valid   <= 1'b1;
						left        <= 1'b0;
						event_addr  <= '0;
						last_result <= 1'b1;
						state_q     <= ST_RESP;
					end
				end
				ST_RESP: begin
					if (out_ready) begin
						out_valid <= 1'b0;
						state_q   <= accept ? ST_EXEC : ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_unique_hit: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(hit_vec))
		else $error("address held by more than one slot");
	a_no_out_in_exec: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EXEC) |-> !out_valid)
		else $error("result pending while a request executes");
	a_scan_token: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> $onehot0(tok_c))
		else $error("more than one scan token in the chain");
	a_leave_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && last_result && state_q != ST_RESP) |-> 1'b0)
		else $error("final result shown outside response state");
`endif

endmodule
`default_nettype wire

@@ sv/pht_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none
module pht_cell #(
	parameter int ADDR_BITS = 48
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire pht_pkg::cell_cmd_t       cmd,
	input  wire logic [ADDR_BITS-1:0]     addr,
	input  wire logic [pht_pkg::TIME_W-1:0] now_time,
	input  wire logic [pht_pkg::TIME_W-1:0] timeout,
	input  wire logic                     hit_any,
	input  wire logic                     free_in,
	input  wire logic                     tok_in,
	output logic                          free_out,
	output logic                          tok_out,
	output pht_pkg::cell_stat_t           stat,
	output logic [ADDR_BITS-1:0]          leave_addr
);
	import pht_pkg::*;

	logic                 valid_q, pend_q, tok_q;
	logic [ADDR_BITS-1:0] addr_q;
	hs_t                  hs_q;
	logic                 ann_q;
	logic [TIME_W-1:0]    last_q;

	logic                 hit, free, alloc, tgt, stale;
	hs_t                  cur_hs, n_hs;
	logic                 cur_ann, n_ann, n_valid;
	logic [TIME_W-1:0]    n_last, elapsed;
	logic                 rs, ra, jn, lf;

	assign hit      = valid_q && (addr_q == addr);
	assign free     = !valid_q;
	assign free_out = free_in || free;
	// lowest free slot takes a new peer
	assign alloc    = free && !free_in && !hit_any &&
		(cmd.op == OP_ANNOUNCE || cmd.op == OP_CONNECT);
	assign tgt      = hit || alloc;
	assign elapsed  = now_time - last_q;
	assign stale    = valid_q && (elapsed > timeout);

	always_comb begin
		cur_hs  = alloc ? HS_IDLE : hs_q;
		cur_ann = alloc ? (cmd.op == OP_ANNOUNCE) : ann_q;
		n_valid = valid_q || alloc;
		n_hs    = cur_hs;
		n_ann   = cur_ann;
		n_last  = last_q;
		rs = 1'b0; ra = 1'b0; jn = 1'b0; lf = 1'b0;
		if (tgt) begin
			unique case (cmd.op)
				OP_ANNOUNCE: begin
					n_last = now_time;
					if (hit && !ann_q) begin
						n_ann = 1'b1;
						jn    = (hs_q == HS_CONFIRMED);
					end
				end
				OP_LEAVE: begin
					n_valid = 1'b0;
					lf      = ann_q && (hs_q == HS_CONFIRMED);
				end
				OP_CONNECT: begin
					n_last = now_time;
					unique case (cur_hs)
						HS_IDLE: begin
							if (cmd.syn) begin
								n_hs = HS_SYN_RECEIVED; rs = 1'b1; ra = 1'b1;
							end
						end
						HS_SYN_SENT: begin
							if (cmd.syn && cmd.ack) begin
								n_hs = HS_CONFIRMED; ra = 1'b1; jn = cur_ann;
							end else if (cmd.syn) begin
								n_hs = HS_SYN_RECEIVED; rs = 1'b1; ra = 1'b1;
							end
						end
						HS_SYN_RECEIVED: begin
							if (cmd.ack && !cmd.syn) begin
								n_hs = HS_CONFIRMED; jn = cur_ann;
							end else if (cmd.syn && cmd.ack) begin
								n_hs = HS_CONFIRMED; ra = 1'b1; jn = cur_ann;
							end
						end
						HS_CONFIRMED: begin
							if (cmd.syn && cmd.ack) begin
								ra = 1'b1;
							end else if (cmd.syn) begin
								rs = 1'b1; ra = 1'b1;
							end
						end
						default: n_hs = cur_hs;
					endcase
				end
				OP_MARK_SYN: begin
					if (cur_hs == HS_IDLE) n_hs = HS_SYN_SENT;
				end
				OP_TOUCH: n_last = now_time;
				default: n_last = last_q;
			endcase
		end
	end

	always_comb begin
		stat.hit      = hit;
		stat.free     = free;
		stat.rs       = rs;
		stat.ra       = ra;
		stat.jn       = jn;
		stat.lf       = lf;
		stat.present  = tgt && n_valid;
		stat.conn     = tgt && n_valid && n_ann && (n_hs == HS_CONFIRMED);
		stat.pend_tok = tok_q && pend_q;
	end

	assign tok_out    = tok_q;
	assign leave_addr = (tok_q && pend_q) ? addr_q : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			pend_q  <= 1'b0;
			tok_q   <= 1'b0;
		end else begin
			if (cmd.shift) tok_q <= tok_in;
			if (cmd.exec) begin
				if (cmd.op == OP_SCAN) begin
					valid_q <= valid_q && !stale;
					pend_q  <= stale && ann_q && (hs_q == HS_CONFIRMED);
				end else if (cmd.op != OP_NONE && tgt) begin
					valid_q <= n_valid;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec && cmd.op != OP_SCAN && cmd.op != OP_NONE && tgt) begin
			hs_q   <= n_hs;
			ann_q  <= n_ann;
			last_q <= n_last;
			if (alloc) addr_q <= addr;
		end
	end

endmodule
`default_nettype wire
